>>> design/ialu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ialu_pkg: opcodes and function codes of the integer ALU
// Encodings of the MIPS-like subset that the execute-stage ALU decodes.
// ----------------------------------------------------------------------------
package ialu_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned CODE_W  = 6;
	localparam int unsigned SHAMT_W = 5;
	localparam int unsigned IMM_W   = 16;

	// Primary opcode that selects the function code field.
	localparam logic [CODE_W-1:0] OP_RTYPE = 6'h00;

	// Register-type function codes.
	localparam logic [CODE_W-1:0] FN_SLL   = 6'h00;
	localparam logic [CODE_W-1:0] FN_SRL   = 6'h02;
	localparam logic [CODE_W-1:0] FN_SRA   = 6'h03;
	localparam logic [CODE_W-1:0] FN_MFHI  = 6'h10;
	localparam logic [CODE_W-1:0] FN_MFLO  = 6'h12;
	localparam logic [CODE_W-1:0] FN_MULT  = 6'h18;
	localparam logic [CODE_W-1:0] FN_MULTU = 6'h19;
	localparam logic [CODE_W-1:0] FN_ADD   = 6'h20;
	localparam logic [CODE_W-1:0] FN_ADDU  = 6'h21;
	localparam logic [CODE_W-1:0] FN_SUB   = 6'h22;
	localparam logic [CODE_W-1:0] FN_AND   = 6'h24;
	localparam logic [CODE_W-1:0] FN_OR    = 6'h25;
	localparam logic [CODE_W-1:0] FN_XOR   = 6'h26;
	localparam logic [CODE_W-1:0] FN_NOR   = 6'h27;
	localparam logic [CODE_W-1:0] FN_NAND  = 6'h28;
	localparam logic [CODE_W-1:0] FN_SLT   = 6'h2A;

	// Immediate-type opcodes.
	localparam logic [CODE_W-1:0] OP_ADDI  = 6'h08;
	localparam logic [CODE_W-1:0] OP_ADDIU = 6'h09;
	localparam logic [CODE_W-1:0] OP_SLTI  = 6'h0A;
	localparam logic [CODE_W-1:0] OP_ANDI  = 6'h0C;
	localparam logic [CODE_W-1:0] OP_ORI   = 6'h0D;
	localparam logic [CODE_W-1:0] OP_NORI  = 6'h0E;
	localparam logic [CODE_W-1:0] OP_LUI   = 6'h0F;

	// Loads and stores: the ALU forms the address.
	localparam logic [CODE_W-1:0] OP_LB    = 6'h20;
	localparam logic [CODE_W-1:0] OP_LH    = 6'h21;
	localparam logic [CODE_W-1:0] OP_LW    = 6'h23;
	localparam logic [CODE_W-1:0] OP_LBU   = 6'h24;
	localparam logic [CODE_W-1:0] OP_LHU   = 6'h25;
	localparam logic [CODE_W-1:0] OP_SB    = 6'h28;
	localparam logic [CODE_W-1:0] OP_SH    = 6'h29;
	localparam logic [CODE_W-1:0] OP_SW    = 6'h2B;

endpackage

>>> design/integer_alu_with_hi_lo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_alu_with_hi_lo: execute-stage integer ALU with HI and LO
// Computes arithmetic, logic, shift, compare and address results, runs the
// 32x32 multiplies into HI/LO and flags a multiply that overwrites an unread HI.
//
//   Channel  Signals                  Contents of one word
//   -------  -----------------------  -----------------------------------------
//   input    in_valid / in_stall      opcode, func, operands, shamt, immediate
//   output   out_valid / out_stall    result, writes_result, overflow, hi_overwrite
//
// A word is registered at the input, evaluated in one pass (one adder or one
// 33x33 multiplier) and registered at the output; one word per cycle is sustained
// while out_stall is low. HI, LO and the read flag change when a word moves
// into the output register, so mfhi/mflo right after a multiply see its product.
// Reset clears both valid bits, HI and LO, and marks HI as read. A stalled
// output holds its word; the input stage keeps accepting while it has room.
// ----------------------------------------------------------------------------
module integer_alu_with_hi_lo (
	input  logic               clk,
	input  logic               arst_n,
	// Input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [5:0]         opcode,
	input  logic [5:0]         func,
	input  logic signed [31:0] first_operand,
	input  logic signed [31:0] second_operand,
	input  logic [4:0]         shift_amount,
	input  logic signed [15:0] immediate,
	// Output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result,
	output logic               writes_result,
	output logic               overflow,
	output logic               hi_overwrite
);

	localparam int unsigned DW = ialu_pkg::DATA_W;

	// Input stage registers.
	logic                          valid_s1;
	logic [ialu_pkg::CODE_W-1:0]   opcode_s1;
	logic [ialu_pkg::CODE_W-1:0]   func_s1;
	logic [DW-1:0]                 rs_s1;
	logic [DW-1:0]                 rt_s1;
	logic [ialu_pkg::SHAMT_W-1:0]  shamt_s1;
	logic [ialu_pkg::IMM_W-1:0]    imm_s1;

	// Architectural state.
	logic [DW-1:0] hi_q;
	logic [DW-1:0] lo_q;
	logic          hi_was_read_q;

	// Output stage registers.
	logic          valid_s2;
	logic [DW-1:0] result_s2;
	logic          wr_s2;
	logic          ovf_s2;
	logic          hov_s2;

	// Handshake control.
	logic in_take;
	logic s1_move;

	// Evaluation of the stage-one word.
	logic [DW-1:0]     simm;
	logic [DW-1:0]     zimm;
	logic [DW-1:0]     add_b;
	logic [DW-1:0]     add_sum;
	logic [DW-1:0]     sub_diff;
	logic              add_ovf;
	logic              sub_ovf;
	logic              lt_reg;
	logic              lt_imm;
	logic signed [DW:0]     mul_a;
	logic signed [DW:0]     mul_b;
	logic signed [2*DW+1:0] mul_full;
	logic              is_mult;
	logic              is_signed_mult;
	logic              reads_hilo;
	logic [DW-1:0]     res_c;
	logic              wr_c;
	logic              ovf_c;

	// The stage-one word moves on when the output register is free or drains.
	assign s1_move  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !s1_move;
	assign in_take  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			opcode_s1 <= opcode;
			func_s1   <= func;
			rs_s1     <= first_operand;
			rt_s1     <= second_operand;
			shamt_s1  <= shift_amount;
			imm_s1    <= immediate;
		end
	end

	// Immediate forms, shared adder for add and address, subtractor, compares.
	always_comb begin
		simm     = {{(DW-ialu_pkg::IMM_W){imm_s1[ialu_pkg::IMM_W-1]}}, imm_s1};
		zimm     = {{(DW-ialu_pkg::IMM_W){1'b0}}, imm_s1};
		add_b    = (opcode_s1 == ialu_pkg::OP_RTYPE) ? rt_s1 : simm;
		add_sum  = rs_s1 + add_b;
		add_ovf  = ~(rs_s1[DW-1] ^ add_b[DW-1]) & (rs_s1[DW-1] ^ add_sum[DW-1]);
		sub_diff = rs_s1 - rt_s1;
		sub_ovf  = (rs_s1[DW-1] ^ rt_s1[DW-1]) & (rs_s1[DW-1] ^ sub_diff[DW-1]);
		lt_reg   = $signed(rs_s1) < $signed(rt_s1);
		lt_imm   = $signed(rs_s1) < $signed(simm);
	end

	// Multiplier: operands extended by one bit, signed or unsigned.
	always_comb begin
		is_mult        = (opcode_s1 == ialu_pkg::OP_RTYPE) &&
		                 (func_s1 == ialu_pkg::FN_MULT || func_s1 == ialu_pkg::FN_MULTU);
		is_signed_mult = (func_s1 == ialu_pkg::FN_MULT);
		reads_hilo     = (opcode_s1 == ialu_pkg::OP_RTYPE) &&
		                 (func_s1 == ialu_pkg::FN_MFHI || func_s1 == ialu_pkg::FN_MFLO);
		mul_a          = {is_signed_mult & rs_s1[DW-1], rs_s1};
		mul_b          = {is_signed_mult & rt_s1[DW-1], rt_s1};
		mul_full       = mul_a * mul_b;
	end

	// Result selection by opcode and function code.
	always_comb begin
		res_c = '0;
		wr_c  = 1'b1;
		ovf_c = 1'b0;
		if (opcode_s1 == ialu_pkg::OP_RTYPE) begin
			case (func_s1)
				ialu_pkg::FN_ADD: begin
					res_c = add_sum;
					ovf_c = add_ovf;
				end
				ialu_pkg::FN_ADDU: res_c = add_sum;
				ialu_pkg::FN_SUB: begin
					res_c = sub_diff;
					ovf_c = sub_ovf;
				end
				ialu_pkg::FN_AND:  res_c = rs_s1 & rt_s1;
				ialu_pkg::FN_OR:   res_c = rs_s1 | rt_s1;
				ialu_pkg::FN_XOR:  res_c = rs_s1 ^ rt_s1;
				ialu_pkg::FN_NOR:  res_c = ~(rs_s1 | rt_s1);
				ialu_pkg::FN_NAND: res_c = ~(rs_s1 & rt_s1);
				ialu_pkg::FN_SLT:  res_c = {{(DW-1){1'b0}}, lt_reg};
				ialu_pkg::FN_SLL:  res_c = rt_s1 << shamt_s1;
				ialu_pkg::FN_SRL:  res_c = rt_s1 >> shamt_s1;
				ialu_pkg::FN_SRA:  res_c = DW'($signed(rt_s1) >>> shamt_s1);
				ialu_pkg::FN_MFHI: res_c = hi_q;
				ialu_pkg::FN_MFLO: res_c = lo_q;
				default:           wr_c  = 1'b0;
			endcase
		end else begin
			case (opcode_s1) inside
				ialu_pkg::OP_ADDI, ialu_pkg::OP_LB, ialu_pkg::OP_LH, ialu_pkg::OP_LW,
				ialu_pkg::OP_LBU, ialu_pkg::OP_LHU, ialu_pkg::OP_SB, ialu_pkg::OP_SH,
				ialu_pkg::OP_SW: begin
					res_c = add_sum;
					ovf_c = add_ovf;
				end
				ialu_pkg::OP_ADDIU: res_c = add_sum;
				ialu_pkg::OP_LUI:   res_c = {imm_s1, {(DW-ialu_pkg::IMM_W){1'b0}}};
				ialu_pkg::OP_ANDI:  res_c = rs_s1 & zimm;
				ialu_pkg::OP_ORI:   res_c = rs_s1 | zimm;
				ialu_pkg::OP_NORI:  res_c = ~(rs_s1 | zimm);
				ialu_pkg::OP_SLTI:  res_c = {{(DW-1){1'b0}}, lt_imm};
				default:            wr_c  = 1'b0;
			endcase
		end
	end

	// HI, LO and the read flag change as the word enters the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q          <= '0;
			lo_q          <= '0;
			hi_was_read_q <= 1'b1;
		end else if (s1_move) begin
			if (is_mult) begin
				hi_q          <= mul_full[2*DW-1:DW];
				lo_q          <= mul_full[DW-1:0];
				hi_was_read_q <= 1'b0;
			end else if (reads_hilo) begin
				hi_was_read_q <= 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_move) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			result_s2 <= res_c;
			wr_s2     <= wr_c;
			ovf_s2    <= ovf_c;
			hov_s2    <= is_mult & ~hi_was_read_q;
		end
	end

	assign out_valid     = valid_s2;
	assign result        = result_s2;
	assign writes_result = wr_s2;
	assign overflow      = ovf_s2;
	assign hi_overwrite  = hov_s2;

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the execute-stage integer ALU with HI and LO
// A queue of instruction words is driven into the ALU. A short directed list
// comes first, then random words in four traffic phases. Each accepted word is
// run through an in-order model of the ALU, and its HI/LO state, and every
// output word is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

	// Codes that the ALU does not compute on.
	localparam logic [ialu_pkg::CODE_W-1:0] OP_BEQ     = 6'h04;
	localparam logic [ialu_pkg::CODE_W-1:0] FN_UNKNOWN = 6'h3F;

	localparam logic [ialu_pkg::CODE_W-1:0] R_FUNCS [16] = '{
		ialu_pkg::FN_ADD, ialu_pkg::FN_ADDU, ialu_pkg::FN_SUB, ialu_pkg::FN_AND,
		ialu_pkg::FN_OR, ialu_pkg::FN_XOR, ialu_pkg::FN_NOR, ialu_pkg::FN_NAND,
		ialu_pkg::FN_SLT, ialu_pkg::FN_SLL, ialu_pkg::FN_SRL, ialu_pkg::FN_SRA,
		ialu_pkg::FN_MULT, ialu_pkg::FN_MULTU, ialu_pkg::FN_MFHI, ialu_pkg::FN_MFLO
	};
	localparam logic [ialu_pkg::CODE_W-1:0] I_OPS [16] = '{
		ialu_pkg::OP_ADDI, ialu_pkg::OP_ADDIU, ialu_pkg::OP_SLTI, ialu_pkg::OP_ANDI,
		ialu_pkg::OP_ORI, ialu_pkg::OP_NORI, ialu_pkg::OP_LUI, ialu_pkg::OP_LB,
		ialu_pkg::OP_LH, ialu_pkg::OP_LW, ialu_pkg::OP_LBU, ialu_pkg::OP_LHU,
		ialu_pkg::OP_SB, ialu_pkg::OP_SH, ialu_pkg::OP_SW, ialu_pkg::OP_ADDI
	};
	localparam logic [ialu_pkg::DATA_W-1:0] EDGE_VALUES [6] = '{
		32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
		32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001
	};
	localparam int RANDOM_PER_PHASE = 137;

	typedef struct packed {
		logic [ialu_pkg::CODE_W-1:0]  opcode;
		logic [ialu_pkg::CODE_W-1:0]  func;
		logic [ialu_pkg::DATA_W-1:0]  a;
		logic [ialu_pkg::DATA_W-1:0]  b;
		logic [ialu_pkg::SHAMT_W-1:0] shamt;
		logic [ialu_pkg::IMM_W-1:0]   imm;
	} alu_word_t;

	typedef struct packed {
		logic [ialu_pkg::DATA_W-1:0] result;
		logic                        wr;
		logic                        ovf;
		logic                        hov;
	} alu_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                               in_valid = 1'b0;
	logic                               in_stall;
	logic [ialu_pkg::CODE_W-1:0]        opcode = '0;
	logic [ialu_pkg::CODE_W-1:0]        func = '0;
	logic signed [ialu_pkg::DATA_W-1:0] first_operand = '0;
	logic signed [ialu_pkg::DATA_W-1:0] second_operand = '0;
	logic [ialu_pkg::SHAMT_W-1:0]       shift_amount = '0;
	logic signed [ialu_pkg::IMM_W-1:0]  immediate = '0;
	logic                               out_valid;
	logic                               out_stall = 1'b0;
	logic signed [ialu_pkg::DATA_W-1:0] result;
	logic                               writes_result;
	logic                               overflow;
	logic                               hi_overwrite;

	alu_word_t pending_words[$];
	alu_out_t  expected_outs[$];
	alu_word_t next_word;
	alu_word_t seen_word;
	alu_out_t  want;

	logic              in_taken = 1'b0;
	int                send_idle_pct = 0;
	int                stall_pct = 0;
	int                mismatch_count = 0;

	// Shadow copy of HI, LO and the read-since-multiply flag.
	logic [ialu_pkg::DATA_W-1:0] hi_q = '0;
	logic [ialu_pkg::DATA_W-1:0] lo_q = '0;
	logic                        hi_read_q = 1'b1;

	integer_alu_with_hi_lo u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.func           (func),
		.first_operand  (first_operand),
		.second_operand (second_operand),
		.shift_amount   (shift_amount),
		.immediate      (immediate),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result         (result),
		.writes_result  (writes_result),
		.overflow       (overflow),
		.hi_overwrite   (hi_overwrite)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Computes the output word of one instruction and updates HI/LO state.
	function automatic alu_out_t alu_predict(alu_word_t w);
		alu_out_t                    o;
		logic [ialu_pkg::DATA_W-1:0] simm;
		logic [ialu_pkg::DATA_W-1:0] zimm;
		logic [63:0]                 prod;
		o = '0;
		o.wr = 1'b1;
		simm = {{16{w.imm[15]}}, w.imm};
		zimm = {16'h0000, w.imm};
		if (w.opcode == ialu_pkg::OP_RTYPE) begin
			case (w.func)
			ialu_pkg::FN_ADD: begin
				o.result = w.a + w.b;
				o.ovf = (w.a[31] == w.b[31]) && (o.result[31] != w.a[31]);
			end
			ialu_pkg::FN_ADDU: o.result = w.a + w.b;
			ialu_pkg::FN_SUB: begin
				// Overflow only when the signs differ and the sign of a flips.
				o.result = w.a - w.b;
				o.ovf = (w.a[31] != w.b[31]) && (o.result[31] != w.a[31]);
			end
			ialu_pkg::FN_AND:  o.result = w.a & w.b;
			ialu_pkg::FN_OR:   o.result = w.a | w.b;
			ialu_pkg::FN_XOR:  o.result = w.a ^ w.b;
			ialu_pkg::FN_NOR:  o.result = ~(w.a | w.b);
			ialu_pkg::FN_NAND: o.result = ~(w.a & w.b);
			ialu_pkg::FN_SLT:  o.result = {31'b0, $signed(w.a) < $signed(w.b)};
			ialu_pkg::FN_SLL:  o.result = w.b << w.shamt;
			ialu_pkg::FN_SRL:  o.result = w.b >> w.shamt;
			ialu_pkg::FN_SRA:  o.result = $signed(w.b) >>> w.shamt;
			ialu_pkg::FN_MULT, ialu_pkg::FN_MULTU: begin
				// The product goes to HI/LO; no register result is written.
				if (w.func == ialu_pkg::FN_MULT)
					prod = {{32{w.a[31]}}, w.a} * {{32{w.b[31]}}, w.b};
				else
					prod = {32'b0, w.a} * {32'b0, w.b};
				o.hov = !hi_read_q;
				o.wr = 1'b0;
				hi_read_q = 1'b0;
				hi_q = prod[63:32];
				lo_q = prod[31:0];
			end
			ialu_pkg::FN_MFHI: begin
				o.result = hi_q;
				hi_read_q = 1'b1;
			end
			ialu_pkg::FN_MFLO: begin
				o.result = lo_q;
				hi_read_q = 1'b1;
			end
			default: o.wr = 1'b0;
			endcase
		end else begin
			case (w.opcode)
			ialu_pkg::OP_ADDI, ialu_pkg::OP_LB, ialu_pkg::OP_LH, ialu_pkg::OP_LW,
			ialu_pkg::OP_LBU, ialu_pkg::OP_LHU, ialu_pkg::OP_SB, ialu_pkg::OP_SH,
			ialu_pkg::OP_SW: begin
				o.result = w.a + simm;
				o.ovf = (w.a[31] == simm[31]) && (o.result[31] != w.a[31]);
			end
			ialu_pkg::OP_ADDIU: o.result = w.a + simm;
			ialu_pkg::OP_LUI:   o.result = {w.imm, 16'h0000};
			ialu_pkg::OP_ANDI:  o.result = w.a & zimm;
			ialu_pkg::OP_ORI:   o.result = w.a | zimm;
			ialu_pkg::OP_NORI:  o.result = ~(w.a | zimm);
			ialu_pkg::OP_SLTI:  o.result = {31'b0, $signed(w.a) < $signed(simm)};
			default:            o.wr = 1'b0;
			endcase
		end
		return o;
	endfunction

	// Operands lean toward the sign and carry boundaries.
	function automatic logic [ialu_pkg::DATA_W-1:0] pick_operand();
		logic [ialu_pkg::DATA_W-1:0] v;
		case ($urandom_range(7))
		0, 1:    v = EDGE_VALUES[$urandom_range(5)];
		2:       v = $urandom_range(15);
		3:       v = -$urandom_range(15);
		default: v = $urandom;
		endcase
		return v;
	endfunction

	// Mostly known instructions with random content, some raw noise codes.
	function automatic alu_word_t random_word();
		alu_word_t w;
		int        pick;
		w.opcode = 6'($urandom_range(63));
		w.func = 6'($urandom_range(63));
		w.a = pick_operand();
		w.b = pick_operand();
		w.shamt = 5'($urandom_range(31));
		w.imm = 16'($urandom_range(16'hFFFF));
		pick = $urandom_range(99);
		if (pick < 55) begin
			w.opcode = ialu_pkg::OP_RTYPE;
			w.func = R_FUNCS[$urandom_range(15)];
		end else if (pick < 90) begin
			w.opcode = I_OPS[$urandom_range(15)];
		end
		return w;
	endfunction

	task automatic push_word(logic [ialu_pkg::CODE_W-1:0] op,
			logic [ialu_pkg::CODE_W-1:0] fn,
			logic [ialu_pkg::DATA_W-1:0] a, logic [ialu_pkg::DATA_W-1:0] b,
			logic [ialu_pkg::SHAMT_W-1:0] sh, logic [ialu_pkg::IMM_W-1:0] imm);
		pending_words.push_back(alu_word_t'{op, fn, a, b, sh, imm});
	endtask

	task automatic report_mismatch(string field, logic [ialu_pkg::DATA_W-1:0] got,
			logic [ialu_pkg::DATA_W-1:0] exp_val);
		mismatch_count++;
		$display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, exp_val);
	endtask

	// Sender: a new word goes out only once the previous one was taken.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_word = pending_words.pop_front();
				opcode <= next_word.opcode;
				func <= next_word.func;
				first_operand <= next_word.a;
				second_operand <= next_word.b;
				shift_amount <= next_word.shamt;
				immediate <= next_word.imm;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall.
	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	// Accepted input words are predicted; accepted output words are checked.
	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
		if (in_valid && !in_stall) begin
			seen_word = {opcode, func, first_operand, second_operand, shift_amount,
				immediate};
			expected_outs.push_back(alu_predict(seen_word));
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_outs.size() == 0) begin
				report_mismatch("word with nothing expected", result, '0);
			end else begin
				want = expected_outs.pop_front();
				if (result !== want.result)
					report_mismatch("result", result, want.result);
				if (writes_result !== want.wr)
					report_mismatch("writes_result", 32'(writes_result), 32'(want.wr));
				if (overflow !== want.ovf)
					report_mismatch("overflow", 32'(overflow), 32'(want.ovf));
				if (hi_overwrite !== want.hov)
					report_mismatch("hi_overwrite", 32'(hi_overwrite), 32'(want.hov));
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int guard;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// HI read straight after reset, then arithmetic edges.
		push_word(ialu_pkg::OP_RTYPE, ialu_pkg::FN_MFHI,
			32'h1234_5678, 32'h0, 5'd0, 16'h0);
		push_word(ialu_pkg::OP_RTYPE, ialu_pkg::FN_ADD,
			32'h7FFF_FFFF, 32'h1, 5'd0, 16'h0);
		push_word(ialu_pkg::OP_RTYPE, ialu_pkg::FN_ADD,
			32'h8000_0000, 32'h8000_0000, 5'd0, 16'h0);
		push_word(ialu_pkg::OP_RTYPE, ialu_pkg::FN_ADDU,
			32'h7FFF_FFFF, 32'h1, 5'd0, 16'h0);
		push_word(ialu_pkg::OP_RTYPE, ialu_pkg::FN_SUB,
			32'h8000_0000, 32'h1, 5'd0, 16'h0);
		push_word(ialu_pkg::OP_RTYPE, ialu_pkg::FN_SUB,
			32'h7FFF_FFFF, 32'hFFFF_FFFF, 5'd0, 16'h0);
		push_word(ialu_pkg::OP_RTYPE, ialu_pkg::FN_SUB,
			32'h0, 32'h8000_0000, 5'd0, 16'h0);
		push_word(ialu_pkg::OP_RTYPE, ialu_pkg::FN_AND,
			32'hFFFF_FFFF, 32'h0F0F_0F0F, 5'd0, 16'h0);
		push_word(ialu_pkg::OP_RTYPE, ialu_pkg::FN_OR,
			32'hF000_0000, 32'h0000_000F, 5'd0, 16'h0);
		push_word(ialu_pkg::OP_RTYPE, ialu_pkg::FN_NOR,
			32'h0, 32'h0, 5'd0, 16'h0);
		push_word(ialu_pkg::OP_RTYPE, ialu_pkg::FN_NAND,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 16'h0);
		push_word(ialu_pkg::OP_RTYPE, ialu_pkg::FN_SLT,
			32'h8000_0000, 32'h7FFF_FFFF, 5'd0, 16'h0);
		push_word(ialu_pkg::OP_RTYPE, ialu_pkg::FN_SLL,
			32'h0, 32'h1, 5'd31, 16'h0);
		push_word(ialu_pkg::OP_RTYPE, ialu_pkg::FN_SRL,
			32'h0, 32'h8000_0000, 5'd31, 16'h0);
		push_word(ialu_pkg::OP_RTYPE, ialu_pkg::FN_SRA,
			32'h0, 32'h8000_0000, 5'd31, 16'h0);
		// Two multiplies with no read between them, then both reads.
		push_word(ialu_pkg::OP_RTYPE, ialu_pkg::FN_MULT,
			32'h8000_0000, 32'h8000_0000, 5'd0, 16'h0);
		push_word(ialu_pkg::OP_RTYPE, ialu_pkg::FN_MULTU,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 16'h0);
		push_word(ialu_pkg::OP_RTYPE, ialu_pkg::FN_MFHI,
			32'h0, 32'h0, 5'd0, 16'h0);
		push_word(ialu_pkg::OP_RTYPE, ialu_pkg::FN_MFLO,
			32'h0, 32'h0, 5'd0, 16'h0);
		// Immediate forms, address adds and codes that do nothing.
		push_word(ialu_pkg::OP_ADDI, 6'h00, 32'h7FFF_FFFF, 32'h0, 5'd0, 16'h7FFF);
		push_word(ialu_pkg::OP_SB, 6'h00, 32'h8000_0000, 32'h0, 5'd0, 16'h8000);
		push_word(ialu_pkg::OP_ADDIU, 6'h00, 32'h0000_1000, 32'h0, 5'd0, 16'hFFFF);
		push_word(ialu_pkg::OP_LUI, 6'h00, 32'h0, 32'h0, 5'd0, 16'hFFFF);
		push_word(ialu_pkg::OP_ANDI, 6'h00, 32'hFFFF_FFFF, 32'h0, 5'd0, 16'h8000);
		push_word(ialu_pkg::OP_NORI, 6'h00, 32'h0, 32'h0, 5'd0, 16'h8000);
		push_word(ialu_pkg::OP_SLTI, 6'h00, 32'hFFFF_FFFB, 32'h0, 5'd0, 16'hFFFF);
		push_word(OP_BEQ, 6'h00, 32'h1, 32'h1, 5'd0, 16'h0010);
		push_word(ialu_pkg::OP_RTYPE, FN_UNKNOWN, 32'h5, 32'h6, 5'd3, 16'h0);

		// Traffic phases: none, sender gaps, receiver stalls, both.
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1) ? 45 : (phase == 3) ? 28 : 0;
			stall_pct = (phase == 2) ? 45 : (phase == 3) ? 28 : 0;
			for (int i = 0; i < RANDOM_PER_PHASE; i++)
				pending_words.push_back(random_word());
			while (pending_words.size() != 0 || in_valid)
				@(negedge clk);
		end

		// Drain the pipeline, then wait on for any stray words.
		guard = 0;
		while (expected_outs.size() != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (10) @(negedge clk);
		if (expected_outs.size() != 0)
			report_mismatch("words never delivered", 32'(expected_outs.size()), '0);

		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
